// ===== sv/lpxy_pkg.sv =====
// ----------------------------------------------------------------------------
// lpxy_pkg
// Shared widths, constants and the CORDIC arctangent table for the
// Lissajous phase-to-XY pipeline.
// ----------------------------------------------------------------------------
package lpxy_pkg;

    localparam int PHASE_BITS = 24;
    localparam int SINE_BITS  = 24;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 2;

    // angles are 32-bit fractions of a turn
    localparam int ANGLE_W = 32;
    localparam int XY_W    = 34;
    localparam int Z_W     = 33;

    localparam int ROT_STEPS = 31;
    // multiply stage + fold stage + rotation stages + rounding stage
    localparam int LATENCY   = ROT_STEPS + 3;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd1304065748;

    localparam logic [CFG_W-1:0] X_MULT_RESET   = 24'd65536;
    localparam logic [CFG_W-1:0] X_OFFSET_RESET = 24'd0;
    localparam logic [CFG_W-1:0] Y_MULT_RESET   = 24'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_MULT   = 2'd0,
        REG_X_OFFSET = 2'd1,
        REG_Y_MULT   = 2'd2
    } cfg_reg_t;

    typedef logic [ANGLE_W-1:0]          angle_t;
    typedef logic signed [SINE_BITS-1:0] sine_t;

    // round(atan(2^-i) / (2*pi) * 2^32)
    localparam logic [ANGLE_W-1:0] ATAN_TURNS [ROT_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1
    };

endpackage

// ===== sv/lpxy_angle.sv =====
// ----------------------------------------------------------------------------
// lpxy_angle
// Two-stage angle front end: scales the phase by the x and y ratios, adds
// the x offset and folds both angles into [-1/4, 1/4] turn.
// ----------------------------------------------------------------------------
module lpxy_angle (
    input  logic                                    clk,
    input  logic                                    en,
    input  logic [lpxy_pkg::PHASE_BITS-1:0]         phase_in,
    input  logic [lpxy_pkg::CFG_W-1:0]              x_mult,
    input  logic [lpxy_pkg::CFG_W-1:0]              x_offset,
    input  logic [lpxy_pkg::CFG_W-1:0]              y_mult,
    output logic signed [lpxy_pkg::ANGLE_W-1:0]     x_z,
    output logic signed [lpxy_pkg::ANGLE_W-1:0]     y_z
);

    localparam int PROD_W = lpxy_pkg::CFG_W + lpxy_pkg::PHASE_BITS + 1;
    localparam int SHIFT  = lpxy_pkg::ANGLE_W - lpxy_pkg::PHASE_BITS;
    localparam int WIDE_W = PROD_W + SHIFT;

    logic signed [PROD_W-1:0] x_prod;
    logic signed [PROD_W-1:0] y_prod;
    logic signed [WIDE_W-1:0] x_wide;
    logic signed [WIDE_W-1:0] y_wide;
    lpxy_pkg::angle_t         x_angle_reg;
    lpxy_pkg::angle_t         y_angle_reg;
    lpxy_pkg::angle_t         x_shifted;
    logic signed [lpxy_pkg::ANGLE_W-1:0] x_z_reg;
    logic signed [lpxy_pkg::ANGLE_W-1:0] y_z_reg;

    // an angle in the second or third quadrant maps to half a turn minus itself
    function automatic logic signed [lpxy_pkg::ANGLE_W-1:0] fold(
        input lpxy_pkg::angle_t u
    );
        logic signed [lpxy_pkg::ANGLE_W-1:0] r;
        if (u[lpxy_pkg::ANGLE_W-1] != u[lpxy_pkg::ANGLE_W-2])
        begin
            r = $signed(32'h8000_0000 - u);
        end
        else
        begin
            r = $signed(u);
        end
        return r;
    endfunction

    assign x_prod = $signed(x_mult) * $signed({1'b0, phase_in});
    assign y_prod = $signed(y_mult) * $signed({1'b0, phase_in});

    // phase is scaled up to 32 fraction bits, ratio carries 16 fraction bits
    assign x_wide = WIDE_W'(x_prod) <<< SHIFT;
    assign y_wide = WIDE_W'(y_prod) <<< SHIFT;

    assign x_shifted = x_angle_reg + {x_offset, 8'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_angle_reg <= x_wide[lpxy_pkg::ANGLE_W+15:16];
            y_angle_reg <= y_wide[lpxy_pkg::ANGLE_W+15:16];
            x_z_reg     <= fold(x_shifted);
            y_z_reg     <= fold(y_angle_reg);
        end
    end

    assign x_z = x_z_reg;
    assign y_z = y_z_reg;

endmodule

// ===== sv/lpxy_cordic.sv =====
// ----------------------------------------------------------------------------
// lpxy_cordic
// Unrolled rotation-mode CORDIC, one micro-rotation per register stage.
// Only the sine (y) leg leaves the last stage.
// ----------------------------------------------------------------------------
module lpxy_cordic (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [lpxy_pkg::ANGLE_W-1:0]  z_in,
    output logic signed [lpxy_pkg::XY_W-1:0]     y_out
);

    localparam int N    = lpxy_pkg::ROT_STEPS;
    localparam int XY_W = lpxy_pkg::XY_W;
    localparam int Z_W  = lpxy_pkg::Z_W;

    logic signed [XY_W-1:0] cx_reg [N-1];
    logic signed [Z_W-1:0]  z_reg  [N-1];
    logic signed [XY_W-1:0] cy_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic signed [XY_W-1:0] cx_prev;
        logic signed [XY_W-1:0] cy_prev;
        logic signed [Z_W-1:0]  z_prev;
        logic signed [XY_W-1:0] cy_new;

        if (i == 0)
        begin : g_first
            assign cx_prev = lpxy_pkg::CORDIC_GAIN;
            assign cy_prev = '0;
            assign z_prev  = Z_W'(z_in);
        end
        else
        begin : g_next
            assign cx_prev = cx_reg[i-1];
            assign cy_prev = cy_reg[i-1];
            assign z_prev  = z_reg[i-1];
        end

        // floor shifts, both legs from the previous values
        always_comb
        begin
            if (!z_prev[Z_W-1])
            begin
                cy_new = cy_prev + (cx_prev >>> i);
            end
            else
            begin
                cy_new = cy_prev - (cx_prev >>> i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cy_reg[i] <= cy_new;
            end
        end

        if (i < N - 1)
        begin : g_carry
            logic signed [XY_W-1:0] cx_new;
            logic signed [Z_W-1:0]  z_new;
            logic signed [Z_W-1:0]  step;

            assign step = Z_W'(lpxy_pkg::ATAN_TURNS[i]);

            always_comb
            begin
                if (!z_prev[Z_W-1])
                begin
                    cx_new = cx_prev - (cy_prev >>> i);
                    z_new  = z_prev - step;
                end
                else
                begin
                    cx_new = cx_prev + (cy_prev >>> i);
                    z_new  = z_prev + step;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    cx_reg[i] <= cx_new;
                    z_reg[i]  <= z_new;
                end
            end
        end
    end

    assign y_out = cy_reg[N-1];

endmodule

// ===== sv/lpxy_round.sv =====
// ----------------------------------------------------------------------------
// lpxy_round
// Output stage: rounds the CORDIC sine to SINE_BITS, clamps it
// symmetrically and registers the result.
// ----------------------------------------------------------------------------
module lpxy_round (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [lpxy_pkg::XY_W-1:0]  y_in,
    output lpxy_pkg::sine_t                   sine
);

    localparam int SH    = lpxy_pkg::ANGLE_W - lpxy_pkg::SINE_BITS;
    localparam int SUM_W = lpxy_pkg::XY_W + 1;
    localparam logic signed [SUM_W-1:0] HALF =
        (SH > 0) ? SUM_W'(64'd1 << (SH - 1)) : '0;
    localparam logic signed [SUM_W-1:0] LIM =
        SUM_W'((64'd1 << (lpxy_pkg::SINE_BITS - 1)) - 64'd1);

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] shifted;
    lpxy_pkg::sine_t         clamped;
    lpxy_pkg::sine_t         sine_reg;

    assign sum     = SUM_W'(y_in) + HALF;
    assign shifted = sum >>> SH;

    always_comb
    begin
        priority if (shifted > LIM)
        begin
            clamped = lpxy_pkg::SINE_BITS'(LIM);
        end
        else if (shifted < -LIM)
        begin
            clamped = lpxy_pkg::SINE_BITS'(-LIM);
        end
        else
        begin
            clamped = lpxy_pkg::SINE_BITS'(shifted);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sine_reg <= clamped;
        end
    end

    assign sine = sine_reg;

endmodule

// ===== sv/lissajous_phase_to_xy.sv =====
// ----------------------------------------------------------------------------
// lissajous_phase_to_xy
// Phase sample in, Lissajous point out: x = sin(a*phase + offset),
// y = sin(b*phase), angles in turns, sines by pipelined CORDIC.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: phase_in with in_valid / in_stall. Output channel:
//   x_value, y_value (signed Q1.23) with out_valid / out_stall.
//   A transaction completes on a clock edge with valid high and stall low.
//   Configuration: cfg_wr_en writes cfg_data to register cfg_index
//   (0 = x ratio, 1 = x offset, 2 = y ratio, 3 ignored); write only idle.
//   Stages: one multiply, one offset/fold, 31 CORDIC micro-rotation and
//   one rounding. Throughput, set by the one-rotation-per-stage CORDIC,
//   is one transaction per cycle unless out_stall holds the output.
//   Reset clears all valid bits and loads ratios of 1.0 and zero offset.
//   When the output is held by out_stall the whole pipeline freezes and
//   in_stall rises; an empty output register keeps the pipeline moving, so
//   a new phase sample is taken whenever it is empty or being drained.
// ----------------------------------------------------------------------------
module lissajous_phase_to_xy (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [lpxy_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lpxy_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [lpxy_pkg::PHASE_BITS-1:0]      phase_in,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output lpxy_pkg::sine_t                      x_value,
    output lpxy_pkg::sine_t                      y_value
);

    localparam int LAT = lpxy_pkg::LATENCY;

    logic [lpxy_pkg::CFG_W-1:0] x_mult_reg;
    logic [lpxy_pkg::CFG_W-1:0] x_offset_reg;
    logic [lpxy_pkg::CFG_W-1:0] y_mult_reg;
    logic [LAT-1:0]             valid_reg;
    logic [LAT-1:0]             valid_next;
    logic                       en;

    logic signed [lpxy_pkg::ANGLE_W-1:0] x_z;
    logic signed [lpxy_pkg::ANGLE_W-1:0] y_z;
    logic signed [lpxy_pkg::XY_W-1:0]    x_sin;
    logic signed [lpxy_pkg::XY_W-1:0]    y_sin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_mult_reg   <= lpxy_pkg::X_MULT_RESET;
            x_offset_reg <= lpxy_pkg::X_OFFSET_RESET;
            y_mult_reg   <= lpxy_pkg::Y_MULT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (lpxy_pkg::cfg_reg_t'(cfg_index))
                lpxy_pkg::REG_X_MULT:   x_mult_reg   <= cfg_data;
                lpxy_pkg::REG_X_OFFSET: x_offset_reg <= cfg_data;
                lpxy_pkg::REG_Y_MULT:   y_mult_reg   <= cfg_data;
                default:                ;
            endcase
        end
    end

    // global advance: the output register is empty or being drained
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    assign valid_next = {valid_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg[LAT-1];

    lpxy_angle u_angle (
        .clk      (clk),
        .en       (en),
        .phase_in (phase_in),
        .x_mult   (x_mult_reg),
        .x_offset (x_offset_reg),
        .y_mult   (y_mult_reg),
        .x_z      (x_z),
        .y_z      (y_z)
    );

    lpxy_cordic u_cordic_x (
        .clk   (clk),
        .en    (en),
        .z_in  (x_z),
        .y_out (x_sin)
    );

    lpxy_cordic u_cordic_y (
        .clk   (clk),
        .en    (en),
        .z_in  (y_z),
        .y_out (y_sin)
    );

    lpxy_round u_round_x (
        .clk  (clk),
        .en   (en),
        .y_in (x_sin),
        .sine (x_value)
    );

    lpxy_round u_round_y (
        .clk  (clk),
        .en   (en),
        .y_in (y_sin),
        .sine (y_value)
    );

    // an accepted transaction enters the first valid slot
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> valid_reg[0])
        else $error("accepted transaction missing from pipeline");

    // a frozen pipeline neither drops nor duplicates transactions
    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg))
        else $error("valid bits moved while pipeline was frozen");

    // an output only appears after its predecessor slot was occupied
    a_output_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(valid_reg[LAT-2]))
        else $error("output valid without a transaction in the last stage");

endmodule
